[src/wti_pkg.sv]
package wti_pkg;

    // Default table depth and alpha precision.
    localparam int WTI_MAX_WAYPOINTS   = 64;
    localparam int WTI_ALPHA_FRAC_BITS = 16;

    // Field widths fixed by the interface.
    localparam int TIME_W  = 32;
    localparam int POS_W   = 32;
    localparam int HEAD_W  = 16;
    localparam int COUNT_W = 7;

    // Request modes.
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_SAMPLE = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOT_INCR = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    // Lanes of the interpolation unit.
    localparam logic [1:0] LANE_X    = 2'd0;
    localparam logic [1:0] LANE_Y    = 2'd1;
    localparam logic [1:0] LANE_Z    = 2'd2;
    localparam logic [1:0] LANE_HEAD = 2'd3;

    // One stored waypoint.
    typedef struct packed {
        logic [TIME_W-1:0]        wtime;
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic signed [POS_W-1:0]  z;
        logic [HEAD_W-1:0]        head;
    } t_row;

    // Control that travels alongside an operand through the interpolation unit.
    typedef struct packed {
        logic       valid;
        logic [1:0] lane;
    } t_lerp_ctl;

endpackage

[src/waypoint_trajectory_interpolator.sv]
// Waypoint trajectory interpolator.
// Input channel (i_in_valid / o_in_stall) takes one request word: load a
// waypoint (time, x, y, z, heading), sample the trajectory at a time, or
// clear the table. Every request returns exactly one result word on the
// output channel (o_out_valid / i_out_stall) with position, heading,
// reached_end, status and the number of stored waypoints.
// Load, clear and empty-table requests go straight to the done state. A
// sample outside the table span reads one stored row. A sample inside the
// span runs a binary search over the time column (a read and a compare per
// probe, one probe per halving of the table), two row reads, a serial
// divider that makes one alpha bit per cycle, then one shared multiplier
// that interpolates x, y, z and heading in turn. The single read port of
// the table and the shared divider and multiplier hold the block to one
// request at a time.
// o_in_stall is high from acceptance until the result has moved into the
// output register; a finished result waits there while the receiver stalls,
// and the next request is accepted meanwhile.
// Reset (synchronous, active low) empties the table and drops any pending
// result. The table memory is not cleared; only rows below the fill count
// are ever read.
module waypoint_trajectory_interpolator #(
    parameter int MAX_WAYPOINTS   = wti_pkg::WTI_MAX_WAYPOINTS,
    parameter int ALPHA_FRAC_BITS = wti_pkg::WTI_ALPHA_FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_mode,
    input  logic [wti_pkg::TIME_W-1:0]     i_wp_time,
    input  logic signed [wti_pkg::POS_W-1:0] i_wp_x,
    input  logic signed [wti_pkg::POS_W-1:0] i_wp_y,
    input  logic signed [wti_pkg::POS_W-1:0] i_wp_z,
    input  logic [wti_pkg::HEAD_W-1:0]     i_wp_heading,
    input  logic [wti_pkg::TIME_W-1:0]     i_sample_time,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic signed [wti_pkg::POS_W-1:0] o_pos_x,
    output logic signed [wti_pkg::POS_W-1:0] o_pos_y,
    output logic signed [wti_pkg::POS_W-1:0] o_pos_z,
    output logic [wti_pkg::HEAD_W-1:0]     o_heading,
    output logic                  o_reached_end,
    output logic [1:0]            o_status,
    output logic [wti_pkg::COUNT_W-1:0]    o_entry_count
);
    import wti_pkg::*;

    localparam int AW = $clog2(MAX_WAYPOINTS);
    localparam int CW = $clog2(MAX_WAYPOINTS + 1);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_SRCH_RD  = 9'b000000010,
        S_SRCH_CMP = 9'b000000100,
        S_RD0      = 9'b000001000,
        S_RD1      = 9'b000010000,
        S_DIV      = 9'b000100000,
        S_LERP     = 9'b001000000,
        S_CLAMP    = 9'b010000000,
        S_DONE     = 9'b100000000
    } t_state;

    t_state              r_state;
    logic [CW-1:0]       r_count;
    logic [TIME_W-1:0]   r_first_time;
    logic [TIME_W-1:0]   r_last_time;
    logic [TIME_W-1:0]   r_t;
    logic [AW-1:0]       r_lo;
    logic [AW-1:0]       r_hi;
    t_row                r_row0;
    t_row                r_row1;
    logic [2:0]          r_issue;
    logic [2:0]          r_got;

    // Result being built, then the output register.
    logic signed [POS_W-1:0] r_res_x;
    logic signed [POS_W-1:0] r_res_y;
    logic signed [POS_W-1:0] r_res_z;
    logic [HEAD_W-1:0]       r_res_head;
    logic                    r_res_end;
    logic [1:0]              r_res_status;
    logic                    r_out_valid;
    logic signed [POS_W-1:0] r_out_x;
    logic signed [POS_W-1:0] r_out_y;
    logic signed [POS_W-1:0] r_out_z;
    logic [HEAD_W-1:0]       r_out_head;
    logic                    r_out_end;
    logic [1:0]              r_out_status;
    logic [COUNT_W-1:0]      r_out_count;

    logic                w_accept;
    logic                w_out_free;
    logic [CW-1:0]       w_last_full;
    logic [AW-1:0]       w_last;
    logic [AW-1:0]       w_mid;
    logic                w_full;
    logic                w_at_end;
    logic                w_at_start;
    logic [AW-1:0]       w_raddr;
    logic                w_we;
    t_row                w_wrow;
    t_row                w_rdata;
    logic                w_div_start;
    logic [31:0]         w_div_num;
    logic [31:0]         w_div_span;
    logic                w_div_done;
    logic [ALPHA_FRAC_BITS-1:0] w_alpha;
    t_lerp_ctl           w_lerp_in;
    t_lerp_ctl           w_lerp_out;
    logic signed [32:0]  w_lerp_a;
    logic signed [32:0]  w_lerp_d;
    logic [31:0]         w_lerp_res;
    logic [HEAD_W-1:0]   w_head_diff;
    logic [CW+COUNT_W-1:0] w_count_ext;

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;

    assign w_last_full = r_count - CW'(1);
    assign w_last      = w_last_full[AW-1:0];
    assign w_mid       = r_lo + ((r_hi - r_lo) >> 1);
    assign w_full      = (r_count >= CW'(MAX_WAYPOINTS));
    assign w_at_end    = (i_sample_time >= r_last_time);
    assign w_at_start  = (i_sample_time <= r_first_time);

    // A load is stored when the table has room and the time moves forward.
    assign w_we = w_accept && (i_mode == MODE_LOAD) && !w_full &&
                  ((r_count == '0) || (i_wp_time > r_last_time));
    assign w_wrow.wtime = i_wp_time;
    assign w_wrow.x     = i_wp_x;
    assign w_wrow.y     = i_wp_y;
    assign w_wrow.z     = i_wp_z;
    assign w_wrow.head  = i_wp_heading;

    // Read address: the clamp row on acceptance, the probe row during the
    // search, then the two rows that bracket the sample time.
    always_comb begin
        w_raddr = '0;
        case (r_state)
            S_IDLE:    w_raddr = w_at_start ? '0 : w_last;
            S_SRCH_RD: w_raddr = (r_lo < r_hi) ? w_mid : (r_lo - AW'(1));
            S_RD0:     w_raddr = r_lo;
            default:   w_raddr = '0;
        endcase
    end

    wti_mem #(
        .DEPTH (MAX_WAYPOINTS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_wrow),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // alpha = floor(((t - t0) << F) / (t1 - t0)); times strictly increase, so
    // the span is never zero.
    assign w_div_start = (r_state == S_RD1);
    assign w_div_num   = r_t - r_row0.wtime;
    assign w_div_span  = w_rdata.wtime - r_row0.wtime;

    wti_div #(
        .FRAC (ALPHA_FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_span  (w_div_span),
        .o_done  (w_div_done),
        .o_quot  (w_alpha)
    );

    // Heading difference along the shortest arc; a half turn counts as
    // counterclockwise.
    assign w_head_diff = r_row1.head - r_row0.head;

    always_comb begin
        w_lerp_in.valid = (r_state == S_LERP) && (r_issue < 3'd4);
        w_lerp_in.lane  = r_issue[1:0];
        case (r_issue[1:0])
            LANE_X: begin
                w_lerp_a = 33'(r_row0.x);
                w_lerp_d = 33'(r_row1.x) - 33'(r_row0.x);
            end
            LANE_Y: begin
                w_lerp_a = 33'(r_row0.y);
                w_lerp_d = 33'(r_row1.y) - 33'(r_row0.y);
            end
            LANE_Z: begin
                w_lerp_a = 33'(r_row0.z);
                w_lerp_d = 33'(r_row1.z) - 33'(r_row0.z);
            end
            default: begin
                w_lerp_a = $signed({17'd0, r_row0.head});
                if (w_head_diff > 16'h8000) begin
                    w_lerp_d = $signed({17'd0, w_head_diff}) - 33'sd65536;
                end else begin
                    w_lerp_d = $signed({17'd0, w_head_diff});
                end
            end
        endcase
    end

    wti_lerp #(
        .FRAC (ALPHA_FRAC_BITS)
    ) u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_lerp_in),
        .i_a     (w_lerp_a),
        .i_d     (w_lerp_d),
        .i_alpha (w_alpha),
        .o_ctl   (w_lerp_out),
        .o_res   (w_lerp_res)
    );

    // Sequencer and table bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_issue <= '0;
            r_got   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_DONE;
                        if (i_mode == MODE_CLEAR) begin
                            r_count <= '0;
                        end else if (w_we) begin
                            r_count <= r_count + CW'(1);
                        end else if ((i_mode == MODE_SAMPLE) && (r_count != '0)) begin
                            if (w_at_start || w_at_end) begin
                                r_state <= S_CLAMP;
                            end else begin
                                r_state <= S_SRCH_RD;
                            end
                        end
                    end
                end
                S_SRCH_RD: begin
                    r_state <= (r_lo < r_hi) ? S_SRCH_CMP : S_RD0;
                end
                S_SRCH_CMP: r_state <= S_SRCH_RD;
                S_RD0:      r_state <= S_RD1;
                S_RD1:      r_state <= S_DIV;
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_LERP;
                        r_issue <= '0;
                        r_got   <= '0;
                    end
                end
                S_LERP: begin
                    if (r_issue < 3'd4) begin
                        r_issue <= r_issue + 3'd1;
                    end
                    if (w_lerp_out.valid) begin
                        r_got <= r_got + 3'd1;
                        if (r_got == 3'd3) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_CLAMP: r_state <= S_DONE;
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers of the sequencer.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_last_time <= i_wp_time;
            if (r_count == '0) begin
                r_first_time <= i_wp_time;
            end
        end
        case (r_state)
            S_IDLE: begin
                r_t          <= i_sample_time;
                r_lo         <= AW'(1);
                r_hi         <= w_last;
                r_res_x      <= '0;
                r_res_y      <= '0;
                r_res_z      <= '0;
                r_res_head   <= '0;
                r_res_end    <= 1'b0;
                r_res_status <= ST_OK;
                if (i_mode == MODE_LOAD) begin
                    if (w_full) begin
                        r_res_status <= ST_FULL;
                    end else if (!w_we) begin
                        r_res_status <= ST_NOT_INCR;
                    end
                end else if (i_mode == MODE_SAMPLE) begin
                    if (r_count == '0) begin
                        r_res_status <= ST_EMPTY;
                    end else begin
                        r_res_end <= w_at_end;
                    end
                end
            end
            S_SRCH_CMP: begin
                if (w_rdata.wtime > r_t) begin
                    r_hi <= w_mid;
                end else begin
                    r_lo <= w_mid + AW'(1);
                end
            end
            S_RD0: r_row0 <= w_rdata;
            S_RD1: r_row1 <= w_rdata;
            S_LERP: begin
                if (w_lerp_out.valid) begin
                    case (w_lerp_out.lane)
                        LANE_X:  r_res_x    <= w_lerp_res;
                        LANE_Y:  r_res_y    <= w_lerp_res;
                        LANE_Z:  r_res_z    <= w_lerp_res;
                        default: r_res_head <= w_lerp_res[HEAD_W-1:0];
                    endcase
                end
            end
            S_CLAMP: begin
                r_res_x    <= w_rdata.x;
                r_res_y    <= w_rdata.y;
                r_res_z    <= w_rdata.z;
                r_res_head <= w_rdata.head;
            end
            default: begin
            end
        endcase
    end

    // Output register: filled from the finished result, emptied when taken.
    assign w_count_ext = (CW + COUNT_W)'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_out_free) begin
            r_out_x      <= r_res_x;
            r_out_y      <= r_res_y;
            r_out_z      <= r_res_z;
            r_out_head   <= r_res_head;
            r_out_end    <= r_res_end;
            r_out_status <= r_res_status;
            r_out_count  <= w_count_ext[COUNT_W-1:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pos_x       = r_out_x;
    assign o_pos_y       = r_out_y;
    assign o_pos_z       = r_out_z;
    assign o_heading     = r_out_head;
    assign o_reached_end = r_out_end;
    assign o_status      = r_out_status;
    assign o_entry_count = r_out_count;

    // The fill count never passes the table depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_WAYPOINTS))
        else $error("fill count beyond table depth");

    // A clear request empties the table at once.
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_mode == MODE_CLEAR)) |=> (r_count == '0))
        else $error("clear did not empty the table");

    // The divider only finishes while the sequencer waits for it.
    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside its state");

    // Interpolation results only arrive while the sequencer collects them.
    a_lerp_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lerp_out.valid |-> (r_state == S_LERP))
        else $error("interpolation result outside its state");

    // The search window stays inside the stored rows.
    a_search_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SRCH_RD) || (r_state == S_SRCH_CMP)) |->
        ((r_lo >= AW'(1)) && (r_lo <= r_hi) && (r_hi <= w_last)))
        else $error("search window out of range");

endmodule

[src/wti_mem.sv]
module wti_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  wti_pkg::t_row   i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output wti_pkg::t_row   o_rdata
);
    import wti_pkg::*;

    t_row r_mem [DEPTH];
    t_row r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/wti_div.sv]
module wti_div #(
    parameter int FRAC = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [31:0]       i_num,
    input  logic [31:0]       i_span,
    output logic              o_done,
    output logic [FRAC-1:0]   o_quot
);
    import wti_pkg::*;

    localparam int CNT_W = $clog2(FRAC + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [31:0]      r_rem;
    logic [31:0]      r_span;
    logic [FRAC-1:0]  r_q;
    logic [32:0]      w_shifted;
    logic [32:0]      w_trial;
    logic             w_fits;

    // Restoring division, one quotient bit per cycle. The numerator is below
    // the span, so the quotient has exactly FRAC bits.
    assign w_shifted = {r_rem, 1'b0};
    assign w_trial   = w_shifted - {1'b0, r_span};
    assign w_fits    = (w_shifted >= {1'b0, r_span});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(FRAC);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_span <= i_span;
        end else if (r_busy) begin
            r_rem <= w_fits ? w_trial[31:0] : w_shifted[31:0];
            r_q   <= {r_q[FRAC-2:0], w_fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

[src/wti_lerp.sv]
module wti_lerp #(
    parameter int FRAC = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  wti_pkg::t_lerp_ctl     i_ctl,
    input  logic signed [32:0]     i_a,
    input  logic signed [32:0]     i_d,
    input  logic [FRAC-1:0]        i_alpha,
    output wti_pkg::t_lerp_ctl     o_ctl,
    output logic [31:0]            o_res
);
    import wti_pkg::*;

    localparam int PW = 34 + FRAC;

    t_lerp_ctl          r_ctl1;
    t_lerp_ctl          r_ctl2;
    logic signed [PW-1:0] r_prod;
    logic signed [32:0]   r_a;
    logic [31:0]          r_res;
    logic signed [PW-1:0] w_scaled;
    logic signed [PW-1:0] w_sum;

    // Stage one multiplies the difference by alpha; stage two takes the floor
    // of the scaled product (arithmetic shift) and adds the start point.
    assign w_scaled = r_prod >>> FRAC;
    assign w_sum    = w_scaled + PW'(r_a);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(i_d) * PW'($signed({1'b0, i_alpha}));
        r_a    <= i_a;
        r_res  <= w_sum[31:0];
    end

    assign o_ctl = r_ctl2;
    assign o_res = r_res;

endmodule

[bench/tb_waypoint_trajectory_interpolator.sv]
module tb_waypoint_trajectory_interpolator;
    import wti_pkg::*;

    // The block answers a mode 3 request without touching its table.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int RANDOM_WORDS   = 1500;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int HOLDOFF_AT     = 400;
    localparam int QUIET_FROM     = 700;
    localparam int QUIET_TO       = 1000;
    localparam int IDLE_PERCENT   = 15;
    localparam int STALL_LIMIT    = 20000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int MAX_REPORTS    = 100;

    // One request word as the sender offers it. The hold flag makes the
    // sender wait until every outstanding result has come back before the
    // word is offered.
    typedef struct {
        logic [1:0]              mode;
        logic [TIME_W-1:0]       wtime;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [HEAD_W-1:0]       head;
        logic [TIME_W-1:0]       stime;
        bit                      hold_for_drain;
    } request_word_t;

    // One result word: the interpolated setpoint plus bookkeeping.
    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [HEAD_W-1:0]       head;
        logic                    reached_end;
        logic [1:0]              status;
        logic [COUNT_W-1:0]      count;
    } setpoint_word_t;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_in_valid    = 1'b0;
    logic [1:0]              i_mode        = MODE_LOAD;
    logic [TIME_W-1:0]       i_wp_time     = '0;
    logic signed [POS_W-1:0] i_wp_x        = '0;
    logic signed [POS_W-1:0] i_wp_y        = '0;
    logic signed [POS_W-1:0] i_wp_z        = '0;
    logic [HEAD_W-1:0]       i_wp_heading  = '0;
    logic [TIME_W-1:0]       i_sample_time = '0;
    logic                    i_out_stall   = 1'b0;

    logic                    o_in_stall;
    logic                    o_out_valid;
    logic signed [POS_W-1:0] o_pos_x;
    logic signed [POS_W-1:0] o_pos_y;
    logic signed [POS_W-1:0] o_pos_z;
    logic [HEAD_W-1:0]       o_heading;
    logic                    o_reached_end;
    logic [1:0]              o_status;
    logic [COUNT_W-1:0]      o_entry_count;

    waypoint_trajectory_interpolator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_wp_time     (i_wp_time),
        .i_wp_x        (i_wp_x),
        .i_wp_y        (i_wp_y),
        .i_wp_z        (i_wp_z),
        .i_wp_heading  (i_wp_heading),
        .i_sample_time (i_sample_time),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_pos_z       (o_pos_z),
        .o_heading     (o_heading),
        .o_reached_end (o_reached_end),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Requests still to be offered, and the setpoints the block owes us, oldest first.
    request_word_t  request_queue[$];
    setpoint_word_t expected_setpoints[$];

    // Shadow copy of the waypoint table, updated as each request is accepted.
    logic [TIME_W-1:0]       wp_time_tbl [WTI_MAX_WAYPOINTS];
    logic signed [POS_W-1:0] wp_x_tbl    [WTI_MAX_WAYPOINTS];
    logic signed [POS_W-1:0] wp_y_tbl    [WTI_MAX_WAYPOINTS];
    logic signed [POS_W-1:0] wp_z_tbl    [WTI_MAX_WAYPOINTS];
    logic [HEAD_W-1:0]       wp_head_tbl [WTI_MAX_WAYPOINTS];
    int                      wp_fill = 0;

    int             error_count     = 0;
    int             words_accepted  = 0;
    int             setpoints_seen  = 0;
    int             holdoff_left    = 0;
    bit             holdoff_done    = 1'b0;
    int             idle_cycles     = 0;
    request_word_t  offered_word;
    setpoint_word_t want_word;

    // Position blend between two waypoints. The product is shifted
    // arithmetically, which rounds toward minus infinity as the block does.
    function automatic logic signed [POS_W-1:0] blend_position(
        logic signed [POS_W-1:0] a, logic signed [POS_W-1:0] b, logic [63:0] alpha);
        longint diff;
        longint step;
        diff = longint'(b) - longint'(a);
        step = (diff * longint'(alpha)) >>> WTI_ALPHA_FRAC_BITS;
        return POS_W'(longint'(a) + step);
    endfunction

    // Heading blend along the shorter arc. A difference of exactly half a
    // turn is kept positive, so the turn goes counterclockwise.
    function automatic logic [HEAD_W-1:0] blend_heading(
        logic [HEAD_W-1:0] a, logic [HEAD_W-1:0] b, logic [63:0] alpha);
        logic [HEAD_W-1:0] wrapped;
        longint diff;
        longint sum;
        wrapped = b - a;
        diff = wrapped;
        if (diff > 32768) begin
            diff = diff - 65536;
        end
        sum = longint'(a) + ((diff * longint'(alpha)) >>> WTI_ALPHA_FRAC_BITS);
        return sum[HEAD_W-1:0];
    endfunction

    // Applies one accepted request to the shadow table and returns the
    // setpoint word the block must answer with.
    function automatic setpoint_word_t predict_setpoint(request_word_t rq);
        setpoint_word_t w;
        int last;
        int pick;
        int upper;
        logic [63:0] span;
        logic [63:0] offset;
        logic [63:0] alpha;
        w = '0;
        case (rq.mode)
            MODE_LOAD: begin
                if (wp_fill >= WTI_MAX_WAYPOINTS) begin
                    w.status = ST_FULL;
                end else if (wp_fill > 0 && rq.wtime <= wp_time_tbl[wp_fill-1]) begin
                    w.status = ST_NOT_INCR;
                end else begin
                    wp_time_tbl[wp_fill] = rq.wtime;
                    wp_x_tbl[wp_fill]    = rq.x;
                    wp_y_tbl[wp_fill]    = rq.y;
                    wp_z_tbl[wp_fill]    = rq.z;
                    wp_head_tbl[wp_fill] = rq.head;
                    wp_fill++;
                end
            end
            MODE_SAMPLE: begin
                if (wp_fill == 0) begin
                    w.status = ST_EMPTY;
                end else begin
                    last = wp_fill - 1;
                    w.reached_end = (rq.stime >= wp_time_tbl[last]);
                    if (rq.stime <= wp_time_tbl[0] || w.reached_end) begin
                        // Outside the span the setpoint clamps to an end waypoint.
                        pick   = (rq.stime <= wp_time_tbl[0]) ? 0 : last;
                        w.x    = wp_x_tbl[pick];
                        w.y    = wp_y_tbl[pick];
                        w.z    = wp_z_tbl[pick];
                        w.head = wp_head_tbl[pick];
                    end else begin
                        // The upper waypoint is the first one later than the sample time.
                        upper = 1;
                        while (wp_time_tbl[upper] <= rq.stime) begin
                            upper++;
                        end
                        span   = {32'b0, wp_time_tbl[upper]} - {32'b0, wp_time_tbl[upper-1]};
                        offset = {32'b0, rq.stime} - {32'b0, wp_time_tbl[upper-1]};
                        alpha  = (offset << WTI_ALPHA_FRAC_BITS) / span;
                        w.x    = blend_position(wp_x_tbl[upper-1], wp_x_tbl[upper], alpha);
                        w.y    = blend_position(wp_y_tbl[upper-1], wp_y_tbl[upper], alpha);
                        w.z    = blend_position(wp_z_tbl[upper-1], wp_z_tbl[upper], alpha);
                        w.head = blend_heading(wp_head_tbl[upper-1], wp_head_tbl[upper],
                                               alpha);
                    end
                end
            end
            MODE_CLEAR: begin
                wp_fill = 0;
            end
            default: begin
                // The unused mode leaves the table alone and answers with zeros.
            end
        endcase
        w.count = wp_fill[COUNT_W-1:0];
        return w;
    endfunction

    function automatic void add_request(logic [1:0] mode, logic [TIME_W-1:0] wtime,
                                        logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                        logic [POS_W-1:0] z, logic [HEAD_W-1:0] head,
                                        logic [TIME_W-1:0] stime, bit hold);
        request_word_t rq;
        rq.mode           = mode;
        rq.wtime          = wtime;
        rq.x              = x;
        rq.y              = y;
        rq.z              = z;
        rq.head           = head;
        rq.stime          = stime;
        rq.hold_for_drain = hold;
        request_queue.insert(request_queue.size(), rq);
    endfunction

    // Mostly full-range positions, with the two extremes mixed in.
    function automatic logic [POS_W-1:0] random_position();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // A sample request whose unused load fields carry random noise.
    function automatic void add_sample(logic [TIME_W-1:0] stime);
        add_request(MODE_SAMPLE, $urandom, $urandom, $urandom, $urandom, 16'($urandom),
                    stime, 1'b0);
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            end
        end
    endtask

    // The long quiet stretch: neither side idles while it lasts.
    function automatic bit quiet_stretch();
        return words_accepted >= QUIET_FROM && words_accepted < QUIET_TO;
    endfunction

    // Driver. A word is handed over at an edge where valid is high and the
    // block does not stall; the payload only changes once it has gone.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_setpoints.insert(expected_setpoints.size(),
                                          predict_setpoint(offered_word));
                words_accepted++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (request_queue.size() != 0
                        && !(request_queue[0].hold_for_drain && expected_setpoints.size() != 0)
                        && (quiet_stretch() || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                    offered_word   = request_queue.pop_front();
                    i_in_valid    <= 1'b1;
                    i_mode        <= offered_word.mode;
                    i_wp_time     <= offered_word.wtime;
                    i_wp_x        <= offered_word.x;
                    i_wp_y        <= offered_word.y;
                    i_wp_z        <= offered_word.z;
                    i_wp_heading  <= offered_word.head;
                    i_sample_time <= offered_word.stime;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor. Each setpoint word taken from the block is compared with the
    // oldest prediction. Once, the receiver holds off for a long stretch so
    // that the output register fills and the block stalls its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                setpoints_seen++;
                if (expected_setpoints.size() == 0) begin
                    error_count++;
                    $display("%0t: setpoint word with no request outstanding, expected none, actual x=%h",
                             $time, o_pos_x);
                end else begin
                    want_word = expected_setpoints.pop_front();
                    check_field("pos_x", want_word.x, o_pos_x);
                    check_field("pos_y", want_word.y, o_pos_y);
                    check_field("pos_z", want_word.z, o_pos_z);
                    check_field("heading", 32'(want_word.head), 32'(o_heading));
                    check_field("reached_end", 32'(want_word.reached_end), 32'(o_reached_end));
                    check_field("status", 32'(want_word.status), 32'(o_status));
                    check_field("entry_count", 32'(want_word.count), 32'(o_entry_count));
                end
            end
            if (holdoff_left != 0) begin
                holdoff_left--;
                i_out_stall <= 1'b1;
            end else if (!holdoff_done && setpoints_seen >= HOLDOFF_AT) begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_CYCLES;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !quiet_stretch() && $urandom_range(0, 99) < IDLE_PERCENT;
            end
        end
    end

    // Watchdog: ends the run when neither channel moves a word for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int          directed_words;
        int          n_loads;
        int          n_samples;
        int          i;
        bit          long_seq;
        bit          hold;
        logic [32:0] t_next;
        logic [31:0] seq_first;
        logic [31:0] seq_last;
        logic [31:0] st;
        logic [15:0] head_prev;
        logic [15:0] head_now;

        // Directed part: empty table, single waypoint, extremes of position
        // and time, repeated and older times, the half turn, heading wrap in
        // both directions, samples at and beyond each end, the unused mode
        // and a clear.
        add_request(MODE_SAMPLE, 0, 0, 0, 0, 0, 0, 1'b0);
        add_request(MODE_UNUSED, 0, 0, 0, 0, 0, 0, 1'b0);
        add_request(MODE_LOAD, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 16'h0000, 0, 1'b0);
        add_request(MODE_SAMPLE, 0, 0, 0, 0, 0, 0, 1'b0);
        add_request(MODE_SAMPLE, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 1'b0);
        add_request(MODE_LOAD, 0, 1, 1, 1, 16'h1234, 0, 1'b0);
        add_request(MODE_LOAD, 1000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                    16'h8000, 0, 1'b0);
        add_request(MODE_SAMPLE, 0, 0, 0, 0, 0, 500, 1'b0);
        add_request(MODE_SAMPLE, 0, 0, 0, 0, 0, 1, 1'b0);
        add_request(MODE_SAMPLE, 0, 0, 0, 0, 0, 999, 1'b0);
        add_request(MODE_SAMPLE, 0, 0, 0, 0, 0, 1000, 1'b0);
        add_request(MODE_LOAD, 1001, 0, 0, 1, 16'hFFF0, 0, 1'b0);
        add_request(MODE_LOAD, 70000, 32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678,
                    16'h0010, 0, 1'b0);
        add_request(MODE_LOAD, 32'hFFFF_FFFF, 32'hFFFF_0000, 32'h0001_0000, 32'h8000_0000,
                    16'hFFE0, 0, 1'b0);
        add_request(MODE_SAMPLE, 0, 0, 0, 0, 0, 1000, 1'b0);
        add_request(MODE_SAMPLE, 0, 0, 0, 0, 0, 35000, 1'b0);
        add_request(MODE_SAMPLE, 0, 0, 0, 0, 0, 32'h8000_0000, 1'b0);
        add_request(MODE_SAMPLE, 0, 0, 0, 0, 0, 32'hFFFF_FFFE, 1'b0);
        add_request(MODE_SAMPLE, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 1'b0);
        add_request(MODE_LOAD, 32'hFFFF_FFFF, 5, 5, 5, 16'h0005, 0, 1'b0);
        add_request(MODE_LOAD, 5, 5, 5, 5, 16'h0005, 0, 1'b0);
        add_request(MODE_UNUSED, 0, 0, 0, 0, 0, 0, 1'b0);
        add_request(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 1'b0);
        add_request(MODE_SAMPLE, 0, 0, 0, 0, 0, 500, 1'b0);
        directed_words = request_queue.size();

        // Random part: mostly a clear, a run of increasing loads and a burst
        // of samples over the loaded span. Long runs with small gaps fill the
        // table past its depth; repeated times, stale tables, out-of-span
        // samples and the unused mode make up the noise.
        while (request_queue.size() - directed_words < RANDOM_WORDS) begin
            hold = (request_queue.size() == directed_words) || ($urandom_range(0, 19) == 0);
            if ($urandom_range(0, 7) != 0) begin
                add_request(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom,
                            16'($urandom), $urandom, hold);
            end
            long_seq = ($urandom_range(0, 9) == 0);
            n_loads  = long_seq ? $urandom_range(60, 70) : $urandom_range(1, 12);
            case ($urandom_range(0, 3))
                0: t_next = $urandom_range(0, 100);
                1: t_next = long_seq ? $urandom_range(0, 1 << 20) : $urandom;
                2: t_next = $urandom_range(0, 1 << 20);
                default: t_next = 32'hFFFF_0000 + $urandom_range(0, 16'hFFFF);
            endcase
            seq_first = t_next[31:0];
            seq_last  = seq_first;
            head_prev = 16'($urandom);
            for (i = 0; i < n_loads; i++) begin
                if (t_next[32]) begin
                    break;
                end
                if (i > 0 && $urandom_range(0, 11) == 0) begin
                    st = (seq_last >= 3) ? seq_last - $urandom_range(0, 3) : seq_last;
                    add_request(MODE_LOAD, st, random_position(), random_position(),
                                random_position(), 16'($urandom), $urandom, 1'b0);
                end
                head_now = ($urandom_range(0, 5) == 0) ? head_prev ^ 16'h8000 : 16'($urandom);
                add_request(MODE_LOAD, t_next[31:0], random_position(), random_position(),
                            random_position(), head_now, $urandom, 1'b0);
                seq_last  = t_next[31:0];
                head_prev = head_now;
                t_next = t_next + $urandom_range(1, long_seq ? 1024 : (1 << $urandom_range(0, 24)));
                if ($urandom_range(0, 15) == 0) begin
                    add_sample(seq_first + $urandom_range(0, 2000));
                end
            end
            n_samples = $urandom_range(3, 15);
            for (i = 0; i < n_samples; i++) begin
                case ($urandom_range(0, 9))
                    0: add_sample(seq_first);
                    1: add_sample(seq_last);
                    2: add_sample(seq_first - 1);
                    3: add_sample($urandom);
                    4: begin
                        if ($urandom_range(0, 2) == 0) begin
                            add_request(MODE_UNUSED, $urandom, $urandom, $urandom, $urandom,
                                        16'($urandom), $urandom, 1'b0);
                        end else begin
                            add_sample(seq_last + $urandom_range(1, 1000));
                        end
                    end
                    default: begin
                        add_sample(seq_first + 32'({$urandom, $urandom}
                                   % ({32'b0, seq_last - seq_first} + 64'd1)));
                    end
                endcase
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every request has gone in and every setpoint has come out,
        // then give the block time to show any stray word.
        while (request_queue.size() != 0 || i_in_valid || expected_setpoints.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && expected_setpoints.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

[filelist.f]
src/wti_pkg.sv
src/wti_mem.sv
src/wti_div.sv
src/wti_lerp.sv
src/waypoint_trajectory_interpolator.sv
bench/tb_waypoint_trajectory_interpolator.sv
